// ===== rtl/rhsv_pkg.sv =====
// Shared types, widths and constants for the RGB to HSV pixel converter.
package rhsv_pkg;

   // Channel and result widths.
   localparam int PIX_W = 8;
   localparam int HUE_W = 16;
   localparam int PCT_W = 14;

   // Divider geometry: quotients stay below 2**QUO_W, numerators below 2**NUM_W.
   localparam int QUO_W          = 14;
   localparam int NUM_W          = QUO_W + PIX_W;
   localparam int DIV_STEP_BITS  = 2;
   localparam int DIV_STAGES     = QUO_W / DIV_STEP_BITS;

   // Register stages: channel compare, numerator build, divider, output register.
   localparam int PIPE_DEPTH = DIV_STAGES + 3;

   // Scale constants.
   localparam logic [NUM_W-1:0] HUE_SECTOR = NUM_W'(6000);
   localparam logic [NUM_W-1:0] PCT_SCALE  = NUM_W'(10000);
   localparam int               VAL_SHIFT  = 8;
   localparam logic [HUE_W:0]   HUE_GREEN  = (HUE_W+1)'(12000);
   localparam logic [HUE_W:0]   HUE_BLUE   = (HUE_W+1)'(24000);
   localparam logic [HUE_W:0]   HUE_FULL   = (HUE_W+1)'(36000);

   // Hue sector codes, picked by the first channel that holds the maximum.
   localparam logic [1:0] SECT_RED   = 2'd0;
   localparam logic [1:0] SECT_GREEN = 2'd1;
   localparam logic [1:0] SECT_BLUE  = 2'd2;

   // Input beat.
   typedef struct packed {
      logic [PIX_W-1:0] red;
      logic [PIX_W-1:0] green;
      logic [PIX_W-1:0] blue;
   } rhsv_req_type;

   // Output beat.
   typedef struct packed {
      logic [HUE_W-1:0] hue_centideg;
      logic [PCT_W-1:0] saturation_centipct;
      logic [PCT_W-1:0] value_centipct;
   } rhsv_rsp_type;

   // Per-pixel information that travels beside the dividers.
   typedef struct packed {
      logic [1:0]       sect;
      logic             neg;
      logic             grey;
      logic [PCT_W-1:0] value;
   } rhsv_side_type;

   // One restoring division step: shift in one numerator bit, subtract if it fits.
   // Returns the quotient bit on top of the new remainder.
   function automatic logic [PIX_W:0] div_step(input logic [PIX_W-1:0] rem,
                                               input logic             nbit,
                                               input logic [PIX_W-1:0] den);
      logic [PIX_W:0] trial;
      logic [PIX_W:0] diff;
      trial = {rem, nbit};
      diff  = trial - {1'b0, den};
      if (trial >= {1'b0, den}) begin
         div_step = {1'b1, diff[PIX_W-1:0]};
      end else begin
         div_step = {1'b0, trial[PIX_W-1:0]};
      end
   endfunction

endpackage

// ===== rtl/rhsv_div.sv =====
// Pipelined restoring divider lane: a 22-bit numerator by an 8-bit divisor, two bits per stage.
module rhsv_div
   import rhsv_pkg::*;
(
   input  logic             clock,
   input  logic             advance,
   input  logic [NUM_W-1:0] num,
   input  logic [PIX_W-1:0] den,
   output logic [QUO_W-1:0] quo
);

   logic [PIX_W-1:0] rem_ff [DIV_STAGES];
   logic [QUO_W-1:0] low_ff [DIV_STAGES];
   logic [QUO_W-1:0] quo_ff [DIV_STAGES];
   logic [PIX_W-1:0] den_ff [DIV_STAGES];

   logic [PIX_W-1:0] rem_in [DIV_STAGES];
   logic [QUO_W-1:0] low_in [DIV_STAGES];
   logic [QUO_W-1:0] quo_in [DIV_STAGES];
   logic [PIX_W-1:0] den_in [DIV_STAGES];

   // Each stage takes the previous stage's partial remainder and retires two quotient bits.
   // The quotient is known to fit, so the top numerator bits start below the divisor.
   always_comb begin
      logic [PIX_W-1:0] rem;
      logic [QUO_W-1:0] low;
      logic [QUO_W-1:0] q;
      logic [PIX_W-1:0] d;
      logic [PIX_W:0]   res;
      for (int s = 0; s < DIV_STAGES; s++) begin
         if (s == 0) begin
            rem = num[NUM_W-1:QUO_W];
            low = num[QUO_W-1:0];
            q   = '0;
            d   = den;
         end else begin
            rem = rem_ff[s-1];
            low = low_ff[s-1];
            q   = quo_ff[s-1];
            d   = den_ff[s-1];
         end
         for (int k = 0; k < DIV_STEP_BITS; k++) begin
            res = div_step(rem, low[QUO_W-1], d);
            rem = res[PIX_W-1:0];
            q   = {q[QUO_W-2:0], res[PIX_W]};
            low = {low[QUO_W-2:0], 1'b0};
         end
         rem_in[s] = rem;
         low_in[s] = low;
         quo_in[s] = q;
         den_in[s] = d;
      end
   end

   // Stage registers move together with the rest of the pixel pipeline.
   always_ff @(posedge clock) begin
      if (advance) begin
         for (int s = 0; s < DIV_STAGES; s++) begin
            rem_ff[s] <= rem_in[s];
            low_ff[s] <= low_in[s];
            quo_ff[s] <= quo_in[s];
            den_ff[s] <= den_in[s];
         end
      end
   end

   assign quo = quo_ff[DIV_STAGES-1];

endmodule

// ===== rtl/rgb_to_hsv_pixel.sv =====
// Pixel converter from 8-bit RGB to hue, saturation and value in fixed point.
// An accepted input beat passes the channel compare, numerator, divider and output registers on its way to rsp_.
// Throughput: one pixel per cycle; all stages hold while rsp_valid is high and rsp_ready low.
// The two dividers retire two quotient bits per stage and set the seven middle stages.
// Reset clears the stage valid bits only; the pipeline comes up empty.
module rgb_to_hsv_pixel
   import rhsv_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  rhsv_req_type req_pixel,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rhsv_rsp_type rsp_hsv
);

   logic                  advance;
   logic [PIPE_DEPTH-1:0] vld_ff, vld_in;

   // Stage A: channel compare.
   logic [PIX_W-1:0] a_hi_ff, a_hi_in;
   logic [PIX_W-1:0] a_span_ff, a_span_in;
   logic [PIX_W-1:0] a_mag_ff, a_mag_in;
   logic             a_neg_ff, a_neg_in;
   logic [1:0]       a_sect_ff, a_sect_in;

   // Stage B: numerators.
   logic [NUM_W-1:0] b_hue_num_ff, b_hue_num_in;
   logic [NUM_W-1:0] b_sat_num_ff, b_sat_num_in;
   logic [PIX_W-1:0] b_span_ff, b_hi_ff;
   rhsv_side_type    b_side_ff, b_side_in;

   // Sideband delay that matches the divider stages.
   rhsv_side_type    side_ff [DIV_STAGES];

   logic [QUO_W-1:0] hue_quo, sat_quo;
   rhsv_rsp_type     out_ff, out_in;

   // The pipeline moves when the output register is empty or being taken.
   assign advance   = !vld_ff[PIPE_DEPTH-1] || rsp_ready;
   assign req_ready = advance;
   assign rsp_valid = vld_ff[PIPE_DEPTH-1];
   assign rsp_hsv   = out_ff;

   // Valid bits travel with the data.
   assign vld_in = {vld_ff[PIPE_DEPTH-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= vld_in;
      end
   end

   // Find the maximum channel, ties going red then green, and the signed hue difference.
   always_comb begin
      logic [PIX_W-1:0] r, g, b, lo, pos, neg;
      r = req_pixel.red;
      g = req_pixel.green;
      b = req_pixel.blue;
      lo = (g < r) ? g : r;
      lo = (b < lo) ? b : lo;
      if (r >= g && r >= b) begin
         a_sect_in = SECT_RED;
         a_hi_in   = r;
         pos       = g;
         neg       = b;
      end else if (g >= b) begin
         a_sect_in = SECT_GREEN;
         a_hi_in   = g;
         pos       = b;
         neg       = r;
      end else begin
         a_sect_in = SECT_BLUE;
         a_hi_in   = b;
         pos       = r;
         neg       = g;
      end
      a_span_in = a_hi_in - lo;
      a_neg_in  = pos < neg;
      a_mag_in  = a_neg_in ? (neg - pos) : (pos - neg);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         a_hi_ff   <= a_hi_in;
         a_span_ff <= a_span_in;
         a_mag_ff  <= a_mag_in;
         a_neg_ff  <= a_neg_in;
         a_sect_ff <= a_sect_in;
      end
   end

   // Build the numerators; a negative difference is biased so that the floor becomes a ceiling.
   always_comb begin
      logic [NUM_W-1:0] val_wide;
      b_hue_num_in = NUM_W'(a_mag_ff) * HUE_SECTOR;
      if (a_neg_ff) begin
         b_hue_num_in = b_hue_num_in + NUM_W'(a_span_ff) - NUM_W'(1);
      end
      b_sat_num_in    = NUM_W'(a_span_ff) * PCT_SCALE;
      val_wide        = NUM_W'(a_hi_ff) * PCT_SCALE;
      b_side_in.sect  = a_sect_ff;
      b_side_in.neg   = a_neg_ff;
      b_side_in.grey  = (a_span_ff == '0);
      b_side_in.value = val_wide[NUM_W-1:VAL_SHIFT];
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         b_hue_num_ff <= b_hue_num_in;
         b_sat_num_ff <= b_sat_num_in;
         b_span_ff    <= a_span_ff;
         b_hi_ff      <= a_hi_ff;
         b_side_ff    <= b_side_in;
      end
   end

   // Hue quotient: difference over span.
   rhsv_div u_hue_div (
      .clock   (clock),
      .advance (advance),
      .num     (b_hue_num_ff),
      .den     (b_span_ff),
      .quo     (hue_quo)
   );

   // Saturation quotient: span over maximum.
   rhsv_div u_sat_div (
      .clock   (clock),
      .advance (advance),
      .num     (b_sat_num_ff),
      .den     (b_hi_ff),
      .quo     (sat_quo)
   );

   // Sector, sign, grey flag and value wait beside the dividers.
   always_ff @(posedge clock) begin
      if (advance) begin
         side_ff[0] <= b_side_ff;
         for (int s = 1; s < DIV_STAGES; s++) begin
            side_ff[s] <= side_ff[s-1];
         end
      end
   end

   // Add the sector offset, wrap a negative hue, and force zero for a grey pixel.
   always_comb begin
      rhsv_side_type  side;
      logic [HUE_W:0] offset;
      logic [HUE_W:0] q;
      logic [HUE_W:0] hue;
      side = side_ff[DIV_STAGES-1];
      q    = (HUE_W+1)'(hue_quo);
      unique case (side.sect)
         SECT_RED:   offset = '0;
         SECT_GREEN: offset = HUE_GREEN;
         SECT_BLUE:  offset = HUE_BLUE;
         default:    offset = '0;
      endcase
      priority if (!side.neg) begin
         hue = offset + q;
      end else if (q > offset) begin
         hue = HUE_FULL + offset - q;
      end else begin
         hue = offset - q;
      end
      out_in.hue_centideg        = side.grey ? '0 : hue[HUE_W-1:0];
      out_in.saturation_centipct = side.grey ? '0 : PCT_W'(sat_quo);
      out_in.value_centipct      = side.value;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= out_in;
      end
   end

endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench for the RGB to HSV pixel converter.
module tb_top;
   import rhsv_pkg::*;

   // Cycles to let pass after the last expected beat, from the pipeline depth.
   localparam int DRAIN_CYCLES = PIPE_DEPTH + 4;
   // Number of random pixels, and how many of them run at full rate at the end.
   localparam int RANDOM_PIXELS = 1200;
   localparam int FULL_RATE_PIXELS = 200;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   rhsv_req_type req_pixel = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   rhsv_rsp_type rsp_hsv;

   // HSV beats still owed by the converter, oldest first.
   rhsv_rsp_type pending_hsv[$];
   int           mismatch_count = 0;
   // Random idling on both channels is allowed while this is set.
   bit           idle_on = 1'b1;
   int           stall_left = 0;

   rgb_to_hsv_pixel dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_pixel (req_pixel),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_hsv   (rsp_hsv)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Computes the expected hue, saturation and value of one pixel.
   function automatic rhsv_rsp_type hsv_of(input rhsv_req_type px);
      int unsigned  r, g, b, hi, lo, span;
      int unsigned  plus, minus, base, quot, hue, sat, val;
      logic [1:0]   sector;
      rhsv_rsp_type res;
      r = px.red;
      g = px.green;
      b = px.blue;
      hi = (r > g) ? r : g;
      hi = (b > hi) ? b : hi;
      lo = (r < g) ? r : g;
      lo = (b < lo) ? b : lo;
      span = hi - lo;
      val = (hi * PCT_SCALE) >> VAL_SHIFT;
      hue = 0;
      sat = 0;
      if (span != 0) begin
         // The first channel holding the maximum, in red, green, blue order, wins.
         if (hi == r) sector = SECT_RED;
         else if (hi == g) sector = SECT_GREEN;
         else sector = SECT_BLUE;
         case (sector)
            SECT_RED: begin
               plus = g; minus = b; base = 0;
            end
            SECT_GREEN: begin
               plus = b; minus = r; base = HUE_GREEN;
            end
            default: begin
               plus = r; minus = g; base = HUE_BLUE;
            end
         endcase
         if (plus >= minus) begin
            hue = base + (HUE_SECTOR * (plus - minus)) / span;
         end else begin
            // Floor of a negative quotient, wrapped into the last sector if below zero.
            quot = (HUE_SECTOR * (minus - plus) + span - 1) / span;
            hue = (quot > base) ? HUE_FULL + base - quot : base - quot;
         end
         sat = (span * PCT_SCALE) / hi;
      end
      res.hue_centideg = hue[HUE_W-1:0];
      res.saturation_centipct = sat[PCT_W-1:0];
      res.value_centipct = val[PCT_W-1:0];
      return res;
   endfunction

   // Drives one pixel, waits for its acceptance and then idles now and then.
   task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
      rhsv_req_type px;
      px.red = r;
      px.green = g;
      px.blue = b;
      req_valid <= 1'b1;
      req_pixel <= px;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_hsv.push_back(hsv_of(px));
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
   endtask

   // Output side: random stall bursts, and every accepted beat checked in order.
   always @(posedge clock) begin
      rhsv_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_hsv.size() == 0) begin
            $error("output beat with nothing expected: hue %0d sat %0d val %0d",
                   rsp_hsv.hue_centideg, rsp_hsv.saturation_centipct,
                   rsp_hsv.value_centipct);
            mismatch_count++;
         end else begin
            want = pending_hsv.pop_front();
            if (rsp_hsv.hue_centideg !== want.hue_centideg) begin
               $error("hue_centideg: expected %0d, got %0d",
                      want.hue_centideg, rsp_hsv.hue_centideg);
               mismatch_count++;
            end
            if (rsp_hsv.saturation_centipct !== want.saturation_centipct) begin
               $error("saturation_centipct: expected %0d, got %0d",
                      want.saturation_centipct, rsp_hsv.saturation_centipct);
               mismatch_count++;
            end
            if (rsp_hsv.value_centipct !== want.value_centipct) begin
               $error("value_centipct: expected %0d, got %0d",
                      want.value_centipct, rsp_hsv.value_centipct);
               mismatch_count++;
            end
         end
      end
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
         stall_left <= $urandom_range(0, 4);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Grey pixels, black and white among them, give zero hue and saturation.
   task automatic test_grey;
      send_pixel(8'd0, 8'd0, 8'd0);
      send_pixel(8'd255, 8'd255, 8'd255);
      send_pixel(8'd128, 8'd128, 8'd128);
      send_pixel(8'd1, 8'd1, 8'd1);
   endtask

   // Pure primaries, one per sector, and faint red and blue.
   task automatic test_primaries;
      send_pixel(8'd255, 8'd0, 8'd0);
      send_pixel(8'd0, 8'd255, 8'd0);
      send_pixel(8'd0, 8'd0, 8'd255);
      send_pixel(8'd1, 8'd0, 8'd0);
      send_pixel(8'd0, 8'd0, 8'd1);
   endtask

   // Two channels share the maximum: red beats green and blue, green beats blue.
   task automatic test_max_ties;
      send_pixel(8'd255, 8'd255, 8'd0);
      send_pixel(8'd0, 8'd255, 8'd255);
      send_pixel(8'd255, 8'd0, 8'd255);
      send_pixel(8'd200, 8'd200, 8'd10);
      send_pixel(8'd10, 8'd200, 8'd200);
      send_pixel(8'd200, 8'd10, 8'd200);
   endtask

   // Negative differences: floored quotients, and the wrap past zero in the red sector.
   task automatic test_negative_hue;
      send_pixel(8'd255, 8'd0, 8'd1);
      send_pixel(8'd255, 8'd0, 8'd254);
      send_pixel(8'd2, 8'd0, 8'd1);
      send_pixel(8'd200, 8'd100, 8'd150);
      send_pixel(8'd100, 8'd200, 8'd50);
      send_pixel(8'd50, 8'd100, 8'd200);
      send_pixel(8'd254, 8'd3, 8'd7);
   endtask

   // Random pixels, weighted toward greys, ties, extremes and narrow spans.
   task automatic test_random_pixels;
      logic [7:0] ch[3];
      logic [7:0] edge_vals[4];
      int         k, j, mode;
      edge_vals = '{8'd0, 8'd1, 8'd254, 8'd255};
      for (k = 0; k < RANDOM_PIXELS; k++) begin
         if (k == RANDOM_PIXELS - FULL_RATE_PIXELS) idle_on = 1'b0;
         mode = $urandom_range(0, 9);
         for (j = 0; j < 3; j++) ch[j] = 8'($urandom_range(0, 255));
         case (mode)
            6: begin
               ch[1] = ch[0];
               ch[2] = ch[0];
            end
            7: ch[2'($urandom_range(1, 2))] = ch[0];
            8: for (j = 0; j < 3; j++) ch[j] = edge_vals[2'($urandom_range(0, 3))];
            9: for (j = 1; j < 3; j++) ch[j] = ch[0] ^ 8'($urandom_range(0, 3));
            default: ;
         endcase
         send_pixel(ch[0], ch[1], ch[2]);
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_grey();
      test_primaries();
      test_max_ties();
      test_negative_hue();
      test_random_pixels();
      req_valid <= 1'b0;
      while (pending_hsv.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   // Run limit, several times the slowest correct run.
   initial begin
      #5000000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule

// ===== rgb_to_hsv_pixel.f =====
rtl/rhsv_pkg.sv
rtl/rhsv_div.sv
rtl/rgb_to_hsv_pixel.sv
sim/tb_top.sv
